// File: hw/rtl/rphd_pkg.sv
// Package for the ray to plane hit distance block.
// Holds the field widths, the beat types of both channels and the control type
// passed along the pipeline. It depends on nothing else.
package rphd_pkg;

    localparam int COORD_W = 20;
    localparam int DIST_W  = 24;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int ERR_W   = DOT_W + COORD_W + 1;
    localparam int SQ_W    = 2 * ERR_W + 2;
    localparam int D2_W    = 2 * DOT_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] impact_x;
        logic signed [COORD_W-1:0] impact_y;
        logic signed [COORD_W-1:0] impact_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
    } t_in_beat;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              in_front;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic in_front;
    } t_ctl;

endpackage

// File: hw/rtl/rphd_mul_chain.sv
// Pipelined signed multiplier built as a chain of partial product stages.
// Each stage multiplies one slice of the second operand and adds it in.
// Uses rphd_pkg for the control type carried beside the product.
module rphd_mul_chain
    import rphd_pkg::*;
#(
    parameter int AW = 63,
    parameter int BW = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_ctl                 i_ctl,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output t_ctl                 o_ctl,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int CH  = 16;
    localparam int NC  = (BW + CH - 1) / CH;
    localparam int BXW = NC * CH;
    localparam int PW  = AW + BW;

    logic signed [AW-1:0]  w_a   [NC+1];
    logic signed [BXW-1:0] w_b   [NC+1];
    logic signed [PW-1:0]  w_acc [NC+1];
    t_ctl                  w_ctl [NC+1];

    assign w_a[0]   = i_a;
    assign w_b[0]   = BXW'(i_b);
    assign w_acc[0] = '0;
    assign w_ctl[0] = i_ctl;

    for (genvar k = 0; k < NC; k++) begin : g_stage
        logic signed [AW+CH:0]  pp;
        logic signed [AW-1:0]   r_a;
        logic signed [BXW-1:0]  r_b;
        logic signed [PW-1:0]   r_acc;
        t_ctl                   r_ctl;

        if (k == NC - 1) begin : g_top
            assign pp = w_a[k] * $signed(w_b[k][k*CH +: CH]);
        end else begin : g_low
            assign pp = w_a[k] * $signed({1'b0, w_b[k][k*CH +: CH]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[k];
            end
            if (i_en) begin
                r_a   <= w_a[k];
                r_b   <= w_b[k];
                r_acc <= w_acc[k] + (PW'(pp) <<< (CH * k));
            end
        end

        assign w_a[k+1]   = r_a;
        assign w_b[k+1]   = r_b;
        assign w_acc[k+1] = r_acc;
        assign w_ctl[k+1] = r_ctl;
    end

    assign o_ctl = w_ctl[NC];
    assign o_p   = w_acc[NC];

endmodule

// File: hw/rtl/rphd_root_cell.sv
// One cell of the quotient chain: decides a single bit of floor(sqrt(S) / d).
// It keeps the remainder S - (q*d)^2 and q*d^2, using shifts and adds only.
// Uses rphd_pkg for the control type.
module rphd_root_cell
    import rphd_pkg::*;
#(
    parameter int SW  = 128,
    parameter int DW  = 84,
    parameter int QW  = 24,
    parameter int BIT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [SW-1:0]    i_rem,
    input  logic [DW-1:0]    i_d2,
    input  logic [DW+QW-1:0] i_acc,
    input  logic [QW-1:0]    i_quo,
    output t_ctl             o_ctl,
    output logic [SW-1:0]    o_rem,
    output logic [DW-1:0]    o_d2,
    output logic [DW+QW-1:0] o_acc,
    output logic [QW-1:0]    o_quo
);

    localparam int CW = (SW > DW + 2 * QW + 2) ? SW : DW + 2 * QW + 2;

    logic [CW-1:0]    cand;
    logic             take;
    t_ctl             r_ctl;
    logic [SW-1:0]    r_rem;
    logic [DW-1:0]    r_d2;
    logic [DW+QW-1:0] r_acc;
    logic [QW-1:0]    r_quo;

    assign cand = (CW'(i_acc) << (BIT + 1)) + (CW'(i_d2) << (2 * BIT));
    assign take = cand <= CW'(i_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_d2  <= i_d2;
            r_rem <= take ? i_rem - cand[SW-1:0] : i_rem;
            r_acc <= take ? i_acc + ((DW+QW)'(i_d2) << BIT) : i_acc;
            r_quo <= i_quo | (QW'(take) << BIT);
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_d2  = r_d2;
    assign o_acc = r_acc;
    assign o_quo = r_quo;

endmodule

// File: hw/rtl/ray_plane_hit_distance.sv
// Top level of the ray to plane hit distance block.
// Uses rphd_pkg, rphd_mul_chain and rphd_root_cell.
//
//   channel   direction   handshake               beat
//   input     in          i_valid / o_stall       i_in  (t_in_beat)
//   output    out         o_valid / i_stall       o_out (t_out_beat)
//
// One beat is taken every cycle while o_stall is low; a beat passes four
// register stages, the four partial product stages of the squaring chain, the
// sum stage, one quotient cell per bit and the output register.
// Reset is synchronous and active low and clears only valid and control bits.
// A two entry output stage holds results; the pipeline freezes only when both
// entries are full, and o_stall is the registered fullness of the second one.
module ray_plane_hit_distance
    import rphd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_out
);

    logic en;

    // Stage 1: the six coordinate products.
    t_ctl                      r1_ctl;
    logic signed [PROD_W-1:0]  r1_cpx, r1_cpy, r1_cpz, r1_crx, r1_cry, r1_crz;
    t_in_beat                  r1_in;
    // Stage 2: dot products.
    t_ctl                      r2_ctl;
    logic signed [DOT_W-1:0]   r2_d, r2_n;
    t_in_beat                  r2_in;
    // Stage 3: cross terms.
    t_ctl                      r3_ctl;
    logic signed [DOT_W-1:0]   r3_d;
    logic signed [DOT_W+COORD_W-1:0] r3_nrx, r3_nry, r3_nrz, r3_dpx, r3_dpy, r3_dpz;
    // Stage 4: error vector.
    t_ctl                      r4_ctl;
    logic signed [ERR_W-1:0]   r4_ex, r4_ey, r4_ez, r4_d;
    // Squares.
    t_ctl                      sq_ctl, sq_ctl_y, sq_ctl_z, sq_ctl_d;
    logic signed [2*ERR_W-1:0] sq_x, sq_y, sq_z, sq_d;
    // Stage 5: sum of squares.
    t_ctl                      r5_ctl;
    logic [SQ_W-1:0]           r5_s;
    logic [D2_W-1:0]           r5_d2;
    // Output stage.
    logic                      r_out_v, r_skid_v;
    t_out_beat                 r_out, r_skid;
    t_out_beat                 pipe_beat;

    t_ctl                  w_ctl [DIST_W+1];
    logic [SQ_W-1:0]       w_rem [DIST_W+1];
    logic [D2_W-1:0]       w_d2  [DIST_W+1];
    logic [D2_W+DIST_W-1:0] w_acc [DIST_W+1];
    logic [DIST_W-1:0]     w_quo [DIST_W+1];

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (en) begin
            r1_ctl <= '{valid: i_valid, in_front: 1'b0};
            r2_ctl <= r1_ctl;
            r3_ctl <= '{valid: r2_ctl.valid, in_front: (r2_d > 0) && (r2_n > 0)};
            r4_ctl <= r3_ctl;
            r5_ctl <= sq_ctl;
        end
        if (en) begin
            r1_in  <= i_in;
            r1_cpx <= i_in.dir_x * i_in.impact_x;
            r1_cpy <= i_in.dir_y * i_in.impact_y;
            r1_cpz <= i_in.dir_z * i_in.impact_z;
            r1_crx <= i_in.dir_x * i_in.hit_x;
            r1_cry <= i_in.dir_y * i_in.hit_y;
            r1_crz <= i_in.dir_z * i_in.hit_z;
            r2_in  <= r1_in;
            r2_n   <= DOT_W'(r1_cpx) + DOT_W'(r1_cpy) + DOT_W'(r1_cpz);
            r2_d   <= DOT_W'(r1_crx) + DOT_W'(r1_cry) + DOT_W'(r1_crz);
            r3_d   <= r2_d;
            r3_nrx <= r2_n * r2_in.hit_x;
            r3_nry <= r2_n * r2_in.hit_y;
            r3_nrz <= r2_n * r2_in.hit_z;
            r3_dpx <= r2_d * r2_in.impact_x;
            r3_dpy <= r2_d * r2_in.impact_y;
            r3_dpz <= r2_d * r2_in.impact_z;
            r4_ex  <= ERR_W'(r3_nrx) - ERR_W'(r3_dpx);
            r4_ey  <= ERR_W'(r3_nry) - ERR_W'(r3_dpy);
            r4_ez  <= ERR_W'(r3_nrz) - ERR_W'(r3_dpz);
            r4_d   <= ERR_W'(r3_d);
            r5_s   <= SQ_W'(sq_x) + SQ_W'(sq_y) + SQ_W'(sq_z);
            r5_d2  <= sq_d[D2_W-1:0];
        end
    end

    rphd_mul_chain #(.AW(ERR_W), .BW(ERR_W)) u_sq_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_ctl(r4_ctl),
        .i_a(r4_ex), .i_b(r4_ex), .o_ctl(sq_ctl), .o_p(sq_x)
    );
    rphd_mul_chain #(.AW(ERR_W), .BW(ERR_W)) u_sq_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_ctl(r4_ctl),
        .i_a(r4_ey), .i_b(r4_ey), .o_ctl(sq_ctl_y), .o_p(sq_y)
    );
    rphd_mul_chain #(.AW(ERR_W), .BW(ERR_W)) u_sq_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_ctl(r4_ctl),
        .i_a(r4_ez), .i_b(r4_ez), .o_ctl(sq_ctl_z), .o_p(sq_z)
    );
    rphd_mul_chain #(.AW(ERR_W), .BW(ERR_W)) u_sq_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_ctl(r4_ctl),
        .i_a(r4_d), .i_b(r4_d), .o_ctl(sq_ctl_d), .o_p(sq_d)
    );

    assign w_ctl[0] = r5_ctl;
    assign w_rem[0] = r5_s;
    assign w_d2[0]  = r5_d2;
    assign w_acc[0] = '0;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < DIST_W; k++) begin : g_cell
        rphd_root_cell #(
            .SW(SQ_W), .DW(D2_W), .QW(DIST_W), .BIT(DIST_W - 1 - k)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(w_ctl[k]), .i_rem(w_rem[k]), .i_d2(w_d2[k]),
            .i_acc(w_acc[k]), .i_quo(w_quo[k]),
            .o_ctl(w_ctl[k+1]), .o_rem(w_rem[k+1]), .o_d2(w_d2[k+1]),
            .o_acc(w_acc[k+1]), .o_quo(w_quo[k+1])
        );
    end

    assign pipe_beat.in_front = w_ctl[DIST_W].in_front;
    assign pipe_beat.distance = w_ctl[DIST_W].in_front ? w_quo[DIST_W] : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            r_out_v  <= r_skid_v || w_ctl[DIST_W].valid;
            r_skid_v <= 1'b0;
        end else if (en && w_ctl[DIST_W].valid) begin
            r_skid_v <= 1'b1;
        end
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : pipe_beat;
        end else if (en && w_ctl[DIST_W].valid) begin
            r_skid <= pipe_beat;
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("second output entry full while the first is empty");
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall && !r_skid_v && w_ctl[DIST_W].valid) |=> r_skid_v)
        else $error("finished beat dropped while output was stalled");
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_out_v && !r_skid_v))
        else $error("second output entry did not move forward");
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.in_front) |-> (&r_out.distance))
        else $error("beat behind the plane without all-ones distance");
    a_sq_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_ctl_y === sq_ctl) && (sq_ctl_z === sq_ctl) && (sq_ctl_d === sq_ctl))
        else $error("squaring chains out of step");

endmodule
